[design/iidl_pkg.sv]
// iidl_pkg: types and constants of the indexed insert/delete list
// used by iidl_ctrl, iidl_datapath and indexed_insert_delete_list_core
`timescale 1ns / 1ps

package iidl_pkg;

  localparam int DEPTH        = 16;
  localparam int ELEMENT_BITS = 32;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [4:0]              position;
    logic [ELEMENT_BITS-1:0] element_in;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [ELEMENT_BITS-1:0] element_out;
    logic [CNT_W-1:0]        count;
  } rsp_t;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

[design/iidl_ctrl.sv]
// iidl_ctrl: handshake controller of the list, holds the result valid state
// depends on iidl_pkg
`timescale 1ns / 1ps

module iidl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output iidl_pkg::cmd_t   cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign req_stall = (state == S_HOLD) && rsp_stall;
  assign rsp_valid = (state == S_HOLD);
  assign accept    = req_valid && !req_stall;
  assign cmd.exec  = accept;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (accept) state_next = S_HOLD;
        else if (!rsp_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[design/iidl_datapath.sv]
// iidl_datapath: entry registers with per-entry shift muxes, length and result word
// depends on iidl_pkg
`timescale 1ns / 1ps

module iidl_datapath (
  input  logic           clk,
  input  logic           rst,
  input  iidl_pkg::cmd_t cmd,
  input  iidl_pkg::req_t req,
  output iidl_pkg::rsp_t rsp
);

  localparam int CW = iidl_pkg::CNT_W;
  localparam int IW = iidl_pkg::IDX_W;
  localparam int EB = iidl_pkg::ELEMENT_BITS;
  localparam int DP = iidl_pkg::DEPTH;

  logic [EB-1:0] entries [DP];
  logic [CW-1:0] occupied;
  logic [CW-1:0] occupied_next;
  logic [1:0]    st;
  logic [EB-1:0] rd;
  logic          do_ins;
  logic          do_del;
  logic [CW-1:0] pos;

  assign pos = CW'(req.position);

  always_comb begin
    occupied_next = occupied;
    st            = iidl_pkg::ST_OK;
    rd            = '0;
    do_ins        = 1'b0;
    do_del        = 1'b0;
    case (req.kind)
      iidl_pkg::OP_INSERT: begin
        if (pos > occupied) st = iidl_pkg::ST_RANGE;
        else if (occupied == CW'(DP)) st = iidl_pkg::ST_FULL;
        else begin
          do_ins        = 1'b1;
          occupied_next = occupied + CW'(1);
        end
      end
      iidl_pkg::OP_DELETE: begin
        if (pos >= occupied) st = iidl_pkg::ST_RANGE;
        else begin
          do_del        = 1'b1;
          occupied_next = occupied - CW'(1);
        end
      end
      iidl_pkg::OP_READ: begin
        if (pos >= occupied) st = iidl_pkg::ST_RANGE;
        else rd = entries[pos[IW-1:0]];
      end
      default: begin
        occupied_next = '0;
      end
    endcase
  end

  for (genvar i = 0; i < DP; i++) begin : g_entry
    localparam int PREV = (i == 0) ? 0 : i - 1;
    localparam int NEXT = (i == DP - 1) ? i : i + 1;
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_ins) begin
          if (CW'(i) == pos) entries[i] <= req.element_in;
          else if (i > 0 && CW'(i) > pos) entries[i] <= entries[PREV];
        end else if (do_del) begin
          if (i < DP - 1 && CW'(i) >= pos) entries[i] <= entries[NEXT];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) occupied <= '0;
    else if (cmd.exec) occupied <= occupied_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.status      <= st;
      rsp.element_out <= rd;
      rsp.count       <= occupied_next;
    end
  end

endmodule

[design/indexed_insert_delete_list_core.sv]
// indexed_insert_delete_list_core: top level of the indexed insert/delete list
// depends on iidl_pkg, iidl_ctrl and iidl_datapath
//
//   channel  direction  handshake               word
//   req      in         req_valid / req_stall   iidl_pkg::req_t (kind, position, element_in)
//   rsp      out        rsp_valid / rsp_stall   iidl_pkg::rsp_t (status, element_out, count)
//
// each request word executes in the cycle it is accepted; its result word is
// valid the next cycle from the output register; one word per cycle while rsp_stall is low
// the whole operation (parallel shift of all entries) completes in that cycle
// reset empties the list; entries hold no reset value
// a held result under rsp_stall stalls the request side
`timescale 1ns / 1ps

module indexed_insert_delete_list_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  iidl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output iidl_pkg::rsp_t rsp
);

  iidl_pkg::cmd_t cmd;

  iidl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  iidl_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

[tb/testbench.sv]
// testbench: random and directed test of indexed_insert_delete_list_core
// needs iidl_pkg and the core; a scoreboard class keeps a shadow list and checks each result word
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASE_WORDS   = 290;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 20;

  class list_scoreboard;
    logic [iidl_pkg::ELEMENT_BITS-1:0] slots [iidl_pkg::DEPTH];
    int unsigned len;
    iidl_pkg::rsp_t awaited [$];
    int errors;

    function new();
      len = 0;
      errors = 0;
    endfunction

    function void note_request(iidl_pkg::req_t w);
      iidl_pkg::rsp_t e;
      int i;
      e.status = iidl_pkg::ST_OK;
      e.element_out = '0;
      case (w.kind)
        iidl_pkg::OP_INSERT: begin
          if (w.position > len) begin
            e.status = iidl_pkg::ST_RANGE;
          end else if (len >= iidl_pkg::DEPTH) begin
            e.status = iidl_pkg::ST_FULL;
          end else begin
            for (i = len; i > w.position; i--) slots[i] = slots[i-1];
            slots[w.position] = w.element_in;
            len++;
          end
        end
        iidl_pkg::OP_DELETE: begin
          if (w.position >= len) begin
            e.status = iidl_pkg::ST_RANGE;
          end else begin
            for (i = w.position; i + 1 < len; i++) slots[i] = slots[i+1];
            len--;
          end
        end
        iidl_pkg::OP_READ: begin
          if (w.position >= len) e.status = iidl_pkg::ST_RANGE;
          else e.element_out = slots[w.position];
        end
        default: len = 0;
      endcase
      e.count = iidl_pkg::CNT_W'(len);
      awaited.push_back(e);
    endfunction

    function void check_response(iidl_pkg::rsp_t got);
      iidl_pkg::rsp_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result word %h with none expected", $time, got);
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
      end
      if (got.element_out !== e.element_out) begin
        errors++;
        $display("%0t: element_out expected %h got %h", $time, e.element_out, got.element_out);
      end
      if (got.count !== e.count) begin
        errors++;
        $display("%0t: count expected %0d got %0d", $time, e.count, got.count);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  iidl_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  iidl_pkg::rsp_t rsp;

  list_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int handshakes = 0;

  indexed_insert_delete_list_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: random stall, or a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) handshakes++;
      if (rsp_valid && !rsp_stall) begin
        handshakes++;
        sb.check_response(rsp);
      end
    end
  end

  initial begin
    int quiet;
    int seen;
    quiet = 0;
    seen = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (handshakes != seen) begin
        seen = handshakes;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic iidl_pkg::req_t make_word(logic [1:0] kind, int pos,
                                               logic [iidl_pkg::ELEMENT_BITS-1:0] val);
    iidl_pkg::req_t w;
    w.kind = kind;
    w.position = 5'(pos);
    w.element_in = val;
    return w;
  endfunction

  function automatic iidl_pkg::req_t random_word(int len, int fill_pct);
    iidl_pkg::req_t w;
    int r;
    r = $urandom_range(99);
    w.element_in = $urandom;
    if ($urandom_range(9) == 0) w.element_in = $urandom_range(1) ? '1 : '0;
    if (r < 1) w.kind = iidl_pkg::OP_CLEAR;
    else if (r < fill_pct) w.kind = iidl_pkg::OP_INSERT;
    else if (r < fill_pct + (100 - fill_pct) / 2) w.kind = iidl_pkg::OP_DELETE;
    else w.kind = iidl_pkg::OP_READ;
    if ($urandom_range(9) < 2) w.position = 5'($urandom_range(iidl_pkg::DEPTH));
    else if (w.kind == iidl_pkg::OP_INSERT) w.position = 5'($urandom_range(len));
    else w.position = (len == 0) ? 5'd0 : 5'($urandom_range(len - 1));
    return w;
  endfunction

  // valid stays high from word to word unless an idle gap is drawn
  task automatic offer_word(iidl_pkg::req_t w);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!(req_valid && !req_stall)) @(posedge clk);
    sb.note_request(w);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    int burst_left;
    int fill_pct;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, bounds, extreme values, append, full list
    offer_word(make_word(iidl_pkg::OP_READ, 0, '0));
    offer_word(make_word(iidl_pkg::OP_DELETE, 0, '0));
    offer_word(make_word(iidl_pkg::OP_INSERT, 1, 32'h1234_5678));
    offer_word(make_word(iidl_pkg::OP_INSERT, 0, '0));
    offer_word(make_word(iidl_pkg::OP_INSERT, 0, '1));
    offer_word(make_word(iidl_pkg::OP_INSERT, 2, 32'hA5A5_5A5A));
    offer_word(make_word(iidl_pkg::OP_READ, 0, '0));
    offer_word(make_word(iidl_pkg::OP_READ, 2, '1));
    offer_word(make_word(iidl_pkg::OP_READ, 3, '0));
    offer_word(make_word(iidl_pkg::OP_DELETE, 1, '0));
    for (n = 0; n < 14; n++) begin
      offer_word(make_word(iidl_pkg::OP_INSERT, $urandom_range(sb.len), $urandom));
    end
    offer_word(make_word(iidl_pkg::OP_INSERT, iidl_pkg::DEPTH, 32'h0BAD_F00D));
    offer_word(make_word(iidl_pkg::OP_INSERT, 3, 32'h0BAD_F00D));
    offer_word(make_word(iidl_pkg::OP_READ, iidl_pkg::DEPTH - 1, '0));
    offer_word(make_word(iidl_pkg::OP_READ, iidl_pkg::DEPTH, '0));
    offer_word(make_word(iidl_pkg::OP_DELETE, iidl_pkg::DEPTH - 1, '0));
    offer_word(make_word(iidl_pkg::OP_DELETE, 0, '0));
    offer_word(make_word(iidl_pkg::OP_CLEAR, 0, '0));
    offer_word(make_word(iidl_pkg::OP_READ, 0, '0));
    wait_drained();

    burst_left = 0;
    fill_pct = 70;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (phase == 0) hold_request = HOLD_CYCLES;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(20, 60);
          case ($urandom_range(2))
            0: fill_pct = 95;
            1: fill_pct = 70;
            default: fill_pct = 25;
          endcase
        end
        burst_left--;
        offer_word(random_word(sb.len, fill_pct));
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
